// ===== hw/rtl/dmd_pkg.sv =====
// ----------------------------------------------------------------------------
// dmd_pkg
// Shared types, codes and constants of the DIME record deframer.
// ----------------------------------------------------------------------------
package dmd_pkg;

  // Decoder phase codes
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_OPTIONS = 3'd1;
  localparam logic [2:0] PH_ID      = 3'd2;
  localparam logic [2:0] PH_TYPE    = 3'd3;
  localparam logic [2:0] PH_DATA    = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_SKIP    = 3'd6;

  // Result kinds
  localparam logic [2:0] KIND_OPTIONS = 3'd0;
  localparam logic [2:0] KIND_ID      = 3'd1;
  localparam logic [2:0] KIND_TYPE    = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_VERSION = 3'd1;
  localparam logic [2:0] ST_NO_MB       = 3'd2;
  localparam logic [2:0] ST_TRUNC_HDR   = 3'd3;
  localparam logic [2:0] ST_TRUNC_BODY  = 3'd4;
  localparam logic [2:0] ST_TRUNC_PAD   = 3'd5;

  // Flag bits of the header flags byte
  localparam int FLAG_MB_BIT = 2;
  localparam int FLAG_ME_BIT = 1;
  localparam int FLAG_CF_BIT = 0;

  localparam logic [3:0] HEADER_BYTES  = 4'd12;
  localparam logic [4:0] VERSION_RESET = 5'd1;
  localparam int         MAX_RESULTS   = 3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       in_first_record;
    logic       begin_flag;
    logic       end_flag;
    logic       chunk_flag;
    logic [3:0] type_format;
    logic [2:0] status;
    logic       last;
  } res_t;

  // Results caused by one input byte, packed from slot 0 up
  typedef struct packed {
    res_t [MAX_RESULTS-1:0] slot;
    logic [1:0]             cnt;
  } res_grp_t;

endpackage

// ===== hw/rtl/dmd_core.sv =====
// ----------------------------------------------------------------------------
// dmd_core
// Record decode state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module dmd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              eoi,
  input  logic [4:0]        version,
  output dmd_pkg::res_grp_t grp
);
  import dmd_pkg::*;

  logic [2:0]  phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [7:0]  flags_byte, flags_byte_next;
  logic [3:0]  format_nibble, format_nibble_next;
  logic [15:0] options_length, options_length_next;
  logic [15:0] id_length, id_length_next;
  logic [15:0] type_length, type_length_next;
  logic [31:0] data_length, data_length_next;
  logic [31:0] remaining, remaining_next;
  logic [1:0]  pad_left, pad_left_next;
  logic        first_record, first_record_next;

  logic [31:0] lens [4];
  logic [3:0]  cnt_inc;
  logic [2:0]  start;
  logic        do_settle;
  logic        found;
  logic [1:0]  pick;
  logic        complete;
  logic        fld_v;
  logic [2:0]  err;
  logic [1:0]  n;
  res_t        r;

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    flags_byte_next     = flags_byte;
    format_nibble_next  = format_nibble;
    options_length_next = options_length;
    id_length_next      = id_length;
    type_length_next    = type_length;
    data_length_next    = data_length;
    remaining_next      = remaining;
    pad_left_next       = pad_left;
    first_record_next   = first_record;
    cnt_inc             = header_count + 4'd1;
    start               = PH_OPTIONS;
    do_settle           = 1'b0;
    complete            = 1'b0;
    fld_v               = 1'b0;
    err                 = ST_OK;
    found               = 1'b0;
    pick                = 2'd0;

    if (phase == PH_SKIP) begin
      if (eoi) begin
        phase_next        = PH_HEADER;
        header_count_next = 4'd0;
        first_record_next = 1'b1;
      end
    end else if (phase inside {[PH_OPTIONS:PH_DATA]}) begin
      if (remaining != 32'd0) begin
        fld_v          = 1'b1;
        remaining_next = remaining - 32'd1;
      end else begin
        pad_left_next = pad_left - 2'd1;
      end
      if (remaining_next == 32'd0 && pad_left_next == 2'd0) begin
        do_settle = 1'b1;
        start     = phase + 3'd1;
      end
    end else begin
      phase_next = PH_HEADER;
      case (header_count)
        4'd0:    flags_byte_next     = in_byte;
        4'd1:    format_nibble_next  = in_byte[7:4];
        4'd2:    options_length_next = {in_byte, 8'd0};
        4'd3:    options_length_next = {options_length[15:8], in_byte};
        4'd4:    id_length_next      = {in_byte, 8'd0};
        4'd5:    id_length_next      = {id_length[15:8], in_byte};
        4'd6:    type_length_next    = {in_byte, 8'd0};
        4'd7:    type_length_next    = {type_length[15:8], in_byte};
        4'd8:    data_length_next    = {in_byte, 24'd0};
        4'd9:    data_length_next    = {data_length[31:24], in_byte, 16'd0};
        4'd10:   data_length_next    = {data_length[31:16], in_byte, 8'd0};
        default: data_length_next    = {data_length[31:8], in_byte};
      endcase
      if (cnt_inc < HEADER_BYTES) begin
        header_count_next = cnt_inc;
        if (eoi) err = ST_TRUNC_HDR;
      end else begin
        header_count_next = 4'd0;
        if (flags_byte_next[7:3] != version) begin
          err = ST_BAD_VERSION;
        end else begin
          do_settle = 1'b1;
          start     = PH_OPTIONS;
        end
      end
    end

    lens[0] = {16'd0, options_length_next};
    lens[1] = {16'd0, id_length_next};
    lens[2] = {16'd0, type_length_next};
    lens[3] = data_length_next;

    // skip empty fields: first nonempty field at or after start
    if (do_settle) begin
      for (int k = 3; k >= 0; k--) begin
        if ((3'(k) + PH_OPTIONS) >= start && lens[k] != 32'd0) begin
          found = 1'b1;
          pick  = 2'(k);
        end
      end
      if (found) begin
        phase_next     = 3'({1'b0, pick} + PH_OPTIONS);
        remaining_next = lens[pick];
        pad_left_next  = 2'(2'd0 - lens[pick][1:0]);
      end else begin
        complete = 1'b1;
      end
    end

    if (err == ST_OK) begin
      if (complete) begin
        if (first_record && !flags_byte_next[FLAG_MB_BIT]) begin
          err = ST_NO_MB;
        end else begin
          first_record_next = 1'b0;
          phase_next        = PH_HEADER;
          header_count_next = 4'd0;
          if (flags_byte_next[FLAG_ME_BIT]) begin
            first_record_next = 1'b1;
          end else if (eoi) begin
            err = ST_TRUNC_PAD;
          end
        end
      end else if (eoi && phase_next inside {[PH_OPTIONS:PH_DATA]}) begin
        err = (remaining_next != 32'd0) ? ST_TRUNC_BODY : ST_TRUNC_PAD;
      end
    end

    if (err != ST_OK) begin
      if (eoi) begin
        phase_next        = PH_HEADER;
        header_count_next = 4'd0;
        first_record_next = 1'b1;
      end else begin
        phase_next = PH_SKIP;
      end
    end
  end

  // Pack results: field byte, record done, error
  always_comb begin
    grp = '0;
    n   = 2'd0;
    r   = '0;
    r.in_first_record = first_record;
    if (fld_v) begin
      grp.slot[n]       = r;
      grp.slot[n].kind  = 3'(phase - PH_OPTIONS);
      grp.slot[n].value = in_byte;
      n = n + 2'd1;
    end
    if (complete && err != ST_NO_MB) begin
      grp.slot[n]             = r;
      grp.slot[n].kind        = KIND_DONE;
      grp.slot[n].begin_flag  = flags_byte_next[FLAG_MB_BIT];
      grp.slot[n].end_flag    = flags_byte_next[FLAG_ME_BIT];
      grp.slot[n].chunk_flag  = flags_byte_next[FLAG_CF_BIT];
      grp.slot[n].type_format = format_nibble_next;
      n = n + 2'd1;
    end
    if (err != ST_OK) begin
      grp.slot[n]        = r;
      grp.slot[n].kind   = KIND_ERROR;
      grp.slot[n].status = err;
      n = n + 2'd1;
    end
    if (n != 2'd0) grp.slot[n - 2'd1].last = 1'b1;
    grp.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= 4'd0;
      first_record <= 1'b1;
      remaining    <= 32'd0;
      pad_left     <= 2'd0;
    end else if (fire) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      first_record <= first_record_next;
      remaining    <= remaining_next;
      pad_left     <= pad_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      flags_byte     <= flags_byte_next;
      format_nibble  <= format_nibble_next;
      options_length <= options_length_next;
      id_length      <= id_length_next;
      type_length    <= type_length_next;
      data_length    <= data_length_next;
    end
  end

endmodule

// ===== hw/rtl/dmd_result_buf.sv =====
// ----------------------------------------------------------------------------
// dmd_result_buf
// Holds the results of one byte and hands them out one per request.
// ----------------------------------------------------------------------------
module dmd_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  dmd_pkg::res_grp_t grp,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output dmd_pkg::res_t     res
);
  import dmd_pkg::*;

  res_t [MAX_RESULTS-1:0] slot;
  logic [1:0]             cnt;
  logic                   take;

  assign out_valid = (cnt != 2'd0);
  assign take      = out_valid && !out_stall;
  // free when empty or the last waiting result leaves this cycle
  assign free      = (cnt == 2'd0) || (cnt == 2'd1 && take);
  assign res       = slot[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= grp.slot;
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule

// ===== hw/rtl/dime_message_deframer_top.sv =====
// ----------------------------------------------------------------------------
// dime_message_deframer_top
// DIME record deframer: one received byte per request in, field bytes,
// record-done flags and errors out.
// ----------------------------------------------------------------------------
// Input channel carries in_byte and end_of_input under in_valid/in_stall.
// Output channel carries one result per request under out_valid/out_stall;
// last marks the final result caused by an input byte. Header and pad bytes
// give no field-byte result.
// A byte is held in the input register and decoded once the result buffer
// is free; its results are registered in the result buffer and shown from it.
// Throughput is one byte per cycle while each byte causes at most one result
// and the receiver does not stall; a byte causing two or three results keeps
// the result buffer busy until taken; the input register holds the next byte.
// version_we/version_data write the expected version; write it only while idle.
// Synchronous reset empties both registers, sets the version to 1 and
// starts a new message. While the receiver stalls, the result buffer holds
// its contents and the input side stalls once the input register is full.
// ----------------------------------------------------------------------------
module dime_message_deframer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  input  logic       version_we,
  input  logic [4:0] version_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic       in_first_record,
  output logic       begin_flag,
  output logic       end_flag,
  output logic       chunk_flag,
  output logic [3:0] type_format,
  output logic [2:0] status,
  output logic       last
);
  import dmd_pkg::*;

  logic       ir_valid;
  logic [7:0] ir_byte;
  logic       ir_eoi;
  logic [4:0] version;
  logic       accept;
  logic       fire;
  logic       free;
  res_grp_t   grp;
  res_t       res;

  assign fire     = ir_valid && free;
  assign in_stall = ir_valid && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (accept) begin
      ir_valid <= 1'b1;
    end else if (fire) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ir_byte <= in_byte;
      ir_eoi  <= end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      version <= VERSION_RESET;
    end else if (version_we) begin
      version <= version_data;
    end
  end

  dmd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_byte (ir_byte),
    .eoi     (ir_eoi),
    .version (version),
    .grp     (grp)
  );

  dmd_result_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .grp       (grp),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign kind            = res.kind;
  assign value           = res.value;
  assign in_first_record = res.in_first_record;
  assign begin_flag      = res.begin_flag;
  assign end_flag        = res.end_flag;
  assign chunk_flag      = res.chunk_flag;
  assign type_format     = res.type_format;
  assign status          = res.status;
  assign last            = res.last;

endmodule
